// File: sv/saa_pkg.sv
// Shared types and constants for the subnet address allocator.
// No dependencies; compiled first.
package saa_pkg;

    localparam int ADDR_W     = 32;
    localparam int PFX_W      = 5;
    localparam int APB_DATA_W = 32;
    localparam int PADDR_W    = 3;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NONE_FREE = 2'd1,
        ST_BAD_ADDR  = 2'd2
    } t_status;

    typedef enum logic {
        REG_NETWORK_ADDR = 1'b0,
        REG_PREFIX_LEN   = 1'b1
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LATCH,
        S_SWEEP,
        S_RSV_RD,
        S_RSV_CHK,
        S_MARK,
        S_MARK_CHK,
        S_AL_CHK,
        S_CLIMB,
        S_SIB_CHK,
        S_DESC_CHK,
        S_FREE_CHK,
        S_CLEAR,
        S_DONE
    } t_state;

endpackage

// File: sv/saa_if.sv
// Valid/ready channel interfaces for request and response beats.
// Depends on saa_pkg.
interface saa_in_if import saa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic              use_given;
    logic [ADDR_W-1:0] address;

    modport source (output valid, output op, output use_given, output address, input ready);
    modport sink   (input valid, input op, input use_given, input address, output ready);
endinterface

interface saa_out_if import saa_pkg::*; #(parameter int FREE_W = 9) ();
    logic              valid;
    logic              ready;
    logic [1:0]        status;
    logic [ADDR_W-1:0] assigned_addr;
    logic [FREE_W-1:0] free_left;

    modport source (output valid, output status, output assigned_addr, output free_left,
                    input ready);
    modport sink   (input valid, input status, input assigned_addr, input free_left,
                    output ready);
endinterface

// File: sv/saa_apb_regs.sv
// APB register file: network address and prefix length.
// Depends on saa_pkg.
module saa_apb_regs import saa_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [ADDR_W-1:0]     o_network_addr,
    output logic [PFX_W-1:0]      o_prefix_len
);

    logic [ADDR_W-1:0] r_network_addr;
    logic [PFX_W-1:0]  r_prefix_len;
    logic              wr_en;
    t_reg_idx          reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_network_addr <= '0;
            r_prefix_len   <= PFX_W'(24);
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_NETWORK_ADDR: r_network_addr <= pwdata[ADDR_W-1:0];
                REG_PREFIX_LEN:   r_prefix_len   <= pwdata[PFX_W-1:0];
                default:          r_prefix_len   <= r_prefix_len;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_NETWORK_ADDR: prdata = APB_DATA_W'(r_network_addr);
            REG_PREFIX_LEN:   prdata = APB_DATA_W'(r_prefix_len);
            default:          prdata = '0;
        endcase
    end

    assign o_network_addr = r_network_addr;
    assign o_prefix_len   = r_prefix_len;

endmodule

// File: sv/saa_engine.sv
// Sequencer plus full-mark tree memory: init sweep, reserve, allocate search, release.
// Depends on saa_pkg.
module saa_engine import saa_pkg::*; #(
    parameter int MAX_HOST_BITS = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [ADDR_W-1:0]        i_network_addr,
    input  logic [PFX_W-1:0]         i_prefix_len,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [1:0]               i_op,
    input  logic                     i_use_given,
    input  logic [ADDR_W-1:0]        i_address,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [1:0]               o_status,
    output logic [ADDR_W-1:0]        o_assigned_addr,
    output logic [MAX_HOST_BITS:0]   o_free_left
);

    localparam int HW    = MAX_HOST_BITS;
    localparam int NW    = MAX_HOST_BITS + 1;
    localparam int CW    = MAX_HOST_BITS + 1;
    localparam int BW    = $clog2(MAX_HOST_BITS + 1);
    localparam int DEPTH = 2 ** NW;

    // tree memory, node 1 is the root, leaves start at 1 << hb
    logic          r_mem [DEPTH];
    logic          r_rdata;
    logic [NW-1:0] mem_raddr;
    logic          mem_we;
    logic [NW-1:0] mem_waddr;
    logic          mem_wdata;

    t_state            r_state, n_state;
    logic [NW-1:0]     r_node, n_node;
    logic [BW-1:0]     r_hb, n_hb;
    logic [ADDR_W-1:0] r_net, n_net;
    logic [CW-1:0]     r_free, n_free;
    logic [1:0]        r_rsv, n_rsv;
    logic              r_init, n_init;
    logic              r_emit, n_emit;
    t_status           r_status, n_status;
    logic [ADDR_W-1:0] r_assigned, n_assigned;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [ADDR_W-1:0] r_out_addr, n_out_addr;
    logic [CW-1:0]     r_out_free, n_out_free;

    logic [PFX_W:0]    hb_raw;
    logic [BW-1:0]     hb_new;
    logic [ADDR_W-1:0] mask_new;
    logic [ADDR_W-1:0] mask32;
    logic [HW-1:0]     mask_h;
    logic [NW-1:0]     leaf_base;
    logic [NW-1:0]     sweep_last;
    logic              in_subnet;
    logic [HW-1:0]     req_host;
    logic [HW-1:0]     start_host;
    logic [HW-1:0]     rsv_host;
    logic [NW-1:0]     sib;
    logic [NW-1:0]     child;
    logic [NW-1:0]     found_node;
    logic              rsv_last;
    logic              accept;
    logic              out_free;
    t_state            mark_end;
    t_state            init_end;

    // pool geometry from the registers
    assign hb_raw   = (PFX_W+1)'(ADDR_W) - {1'b0, i_prefix_len};
    assign hb_new   = (hb_raw > (PFX_W+1)'(MAX_HOST_BITS)) ? BW'(MAX_HOST_BITS) : BW'(hb_raw);
    assign mask_new = ~({ADDR_W{1'b1}} << hb_new);

    assign mask32     = ~({ADDR_W{1'b1}} << r_hb);
    assign mask_h     = mask32[HW-1:0];
    assign leaf_base  = NW'(1) << r_hb;
    assign sweep_last = NW'(leaf_base << 1) - NW'(1);
    assign in_subnet  = ((i_address ^ r_net) & ~mask32) == '0;
    assign req_host   = i_address[HW-1:0] & mask_h;
    assign start_host = i_use_given ? req_host : '0;

    always_comb begin
        case (r_rsv)
            2'd0:    rsv_host = '0;
            2'd1:    rsv_host = mask_h;
            default: rsv_host = mask_h - HW'(1);
        endcase
    end

    assign sib      = r_node | NW'(1);
    assign child    = {r_node[NW-2:0], r_rdata};
    assign rsv_last = (r_rsv == 2'd2);
    assign accept   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;
    assign init_end = r_emit ? S_DONE : S_IDLE;
    assign mark_end = r_init ? (rsv_last ? init_end : S_RSV_RD) : S_DONE;

    // leaf picked by the search, whichever state finds it
    always_comb begin
        unique case (r_state)
            S_SIB_CHK:  found_node = sib;
            S_DESC_CHK: found_node = child;
            default:    found_node = r_node;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        OP_INIT:  n_state = S_LATCH;
                        OP_ALLOC: n_state = (!in_subnet || r_free == '0) ? S_DONE : S_AL_CHK;
                        OP_FREE:  n_state = in_subnet ? S_FREE_CHK : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_LATCH:    n_state = S_SWEEP;
            S_SWEEP:    n_state = (r_node == sweep_last) ? S_RSV_RD : S_SWEEP;
            S_RSV_RD:   n_state = S_RSV_CHK;
            S_RSV_CHK:  n_state = !r_rdata ? S_MARK : (rsv_last ? init_end : S_RSV_RD);
            S_MARK:     n_state = (r_node == NW'(1)) ? mark_end : S_MARK_CHK;
            S_MARK_CHK: n_state = r_rdata ? S_MARK : mark_end;
            S_AL_CHK:   n_state = !r_rdata ? S_MARK : S_CLIMB;
            S_CLIMB: begin
                if (r_node == NW'(1)) begin
                    n_state = S_DONE;
                end else if (r_node[0]) begin
                    n_state = S_CLIMB;
                end else begin
                    n_state = S_SIB_CHK;
                end
            end
            S_SIB_CHK: begin
                if (!r_rdata) begin
                    n_state = |(sib & leaf_base) ? S_MARK : S_DESC_CHK;
                end else begin
                    n_state = S_CLIMB;
                end
            end
            S_DESC_CHK: n_state = |(child & leaf_base) ? S_MARK : S_DESC_CHK;
            S_FREE_CHK: n_state = r_rdata ? S_CLEAR : S_DONE;
            S_CLEAR:    n_state = (r_node == NW'(1)) ? S_DONE : S_CLEAR;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_node       = r_node;
        n_hb         = r_hb;
        n_net        = r_net;
        n_free       = r_free;
        n_rsv        = r_rsv;
        n_init       = r_init;
        n_emit       = r_emit;
        n_status     = r_status;
        n_assigned   = r_assigned;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_addr   = r_out_addr;
        n_out_free   = r_out_free;
        mem_raddr    = '0;
        mem_we       = 1'b0;
        mem_waddr    = r_node;
        mem_wdata    = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_emit     = (i_op == OP_INIT);
                    n_status   = ST_BAD_ADDR;
                    n_assigned = '0;
                    case (i_op)
                        OP_INIT: n_status = ST_OK;
                        OP_ALLOC: begin
                            if (in_subnet) begin
                                n_status  = ST_NONE_FREE;
                                n_node    = leaf_base | {1'b0, start_host};
                                mem_raddr = leaf_base | {1'b0, start_host};
                            end
                        end
                        OP_FREE: begin
                            n_node    = leaf_base | {1'b0, req_host};
                            mem_raddr = leaf_base | {1'b0, req_host};
                        end
                        default: n_status = ST_BAD_ADDR;
                    endcase
                end
            end
            S_LATCH: begin
                n_hb   = hb_new;
                n_net  = i_network_addr & ~mask_new;
                n_free = CW'(1) << hb_new;
                n_node = '0;
                n_rsv  = '0;
                n_init = 1'b1;
            end
            S_SWEEP: begin
                mem_we = 1'b1;
                n_node = r_node + NW'(1);
            end
            S_RSV_RD: begin
                n_node    = leaf_base | {1'b0, rsv_host};
                mem_raddr = leaf_base | {1'b0, rsv_host};
            end
            S_RSV_CHK: begin
                if (!r_rdata) begin
                    n_free = r_free - CW'(1);
                end else begin
                    n_rsv  = r_rsv + 2'd1;
                    n_init = !rsv_last;
                end
            end
            S_MARK: begin
                mem_we    = 1'b1;
                mem_wdata = 1'b1;
                mem_raddr = r_node ^ NW'(1);
                if (r_node == NW'(1) && r_init) begin
                    n_rsv  = r_rsv + 2'd1;
                    n_init = !rsv_last;
                end
            end
            S_MARK_CHK: begin
                // parent is full only when the sibling is full as well
                if (r_rdata) begin
                    n_node = {1'b0, r_node[NW-1:1]};
                end else if (r_init) begin
                    n_rsv  = r_rsv + 2'd1;
                    n_init = !rsv_last;
                end
            end
            S_AL_CHK, S_SIB_CHK, S_DESC_CHK: begin
                if ((r_state == S_AL_CHK && !r_rdata)
                    || (r_state == S_SIB_CHK && !r_rdata && |(sib & leaf_base))
                    || (r_state == S_DESC_CHK && |(child & leaf_base))) begin
                    n_node     = found_node;
                    n_free     = r_free - CW'(1);
                    n_status   = ST_OK;
                    n_assigned = r_net | ADDR_W'(found_node[HW-1:0] & mask_h);
                end else if (r_state == S_SIB_CHK && !r_rdata) begin
                    n_node    = sib;
                    mem_raddr = {sib[NW-2:0], 1'b0};
                end else if (r_state == S_SIB_CHK) begin
                    n_node = {1'b0, r_node[NW-1:1]};
                end else if (r_state == S_DESC_CHK) begin
                    n_node    = child;
                    mem_raddr = {child[NW-2:0], 1'b0};
                end
            end
            S_CLIMB: begin
                // a right child has nothing above it under its parent
                if (r_node != NW'(1)) begin
                    if (r_node[0]) begin
                        n_node = {1'b0, r_node[NW-1:1]};
                    end else begin
                        mem_raddr = sib;
                    end
                end
            end
            S_FREE_CHK: begin
                if (r_rdata) begin
                    n_free   = r_free + CW'(1);
                    n_status = ST_OK;
                end
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                n_node = {1'b0, r_node[NW-1:1]};
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_addr   = r_assigned;
                    n_out_free   = r_free;
                end
            end
            default: n_node = r_node;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LATCH;
            r_hb        <= BW'(MAX_HOST_BITS);
            r_free      <= '0;
            r_rsv       <= '0;
            r_init      <= 1'b0;
            r_emit      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_hb        <= n_hb;
            r_free      <= n_free;
            r_rsv       <= n_rsv;
            r_init      <= n_init;
            r_emit      <= n_emit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node       <= n_node;
        r_net        <= n_net;
        r_status     <= n_status;
        r_assigned   <= n_assigned;
        r_out_status <= n_out_status;
        r_out_addr   <= n_out_addr;
        r_out_free   <= n_out_free;
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_assigned_addr = r_out_addr;
    assign o_free_left     = r_out_free;

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= (CW'(1) << r_hb))
        else $error("free count above pool size");

    a_sweep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (mem_we && !mem_wdata))
        else $error("sweep must write zeros");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_in_ready)
        else $error("ready right after accepting a beat");

    a_descend_inner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DESC_CHK) |-> ((r_node & leaf_base) == '0))
        else $error("descent went past the leaf level");

    a_clear_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR || r_state == S_MARK) |-> (r_node != '0))
        else $error("tree walk reached node zero");

endmodule

// File: sv/subnet_address_allocator_top.sv
// Subnet address allocator: one tree-memory sequencer (one read, one write per cycle), one
// beat in flight: a new beat is taken only after the previous reply is loaded for output, which an
// output stall can hold off. Allocate climbs with sibling reads, descends one level at a time,
// then marks upward; free checks the leaf and, if in use, clears upward to the root; init runs
// a clear sweep of the tree and then reserves the three reserved leaves.
// Reset reloads the default registers and runs the same init internally, ready low till done.
module subnet_address_allocator_top import saa_pkg::*; #(
    parameter int MAX_HOST_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    saa_in_if.sink                i_in,
    saa_out_if.source             o_out
);

    logic [ADDR_W-1:0]      network_addr;
    logic [PFX_W-1:0]       prefix_len;
    logic [MAX_HOST_BITS:0] free_left;

    saa_apb_regs u_regs (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_network_addr (network_addr),
        .o_prefix_len   (prefix_len)
    );

    saa_engine #(
        .MAX_HOST_BITS (MAX_HOST_BITS)
    ) u_engine (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_network_addr  (network_addr),
        .i_prefix_len    (prefix_len),
        .i_in_valid      (i_in.valid),
        .o_in_ready      (i_in.ready),
        .i_op            (i_in.op),
        .i_use_given     (i_in.use_given),
        .i_address       (i_in.address),
        .o_out_valid     (o_out.valid),
        .i_out_ready     (o_out.ready),
        .o_status        (o_out.status),
        .o_assigned_addr (o_out.assigned_addr),
        .o_free_left     (free_left)
    );

    assign o_out.free_left = free_left;

endmodule

// File: verif/subnet_address_allocator_top_tb.sv
// Self-checking testbench for subnet_address_allocator_top: directed and random
// init/allocate/free beats checked against a behavioral pool model.
// Depends on saa_pkg, saa_if.sv and the allocator RTL.
module subnet_address_allocator_top_tb;
    import saa_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_HOST_BITS = 8;
    localparam int FREE_W        = MAX_HOST_BITS + 1;
    localparam int POOL_SLOTS    = 1 << MAX_HOST_BITS;
    localparam int CYCLE_LIMIT   = 4_000_000;
    localparam int DRAIN_CYCLES  = 40;
    localparam int SEG_ITEMS     = 181;
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // one prefix per random segment; segment 4 draws a too-short prefix instead
    localparam logic [4:0] SEG_PFX [0:8] = '{5'd24, 5'd31, 5'd30, 5'd28, 5'd0,
                                             5'd29, 5'd27, 5'd26, 5'd25};

    typedef struct {
        t_status           status;
        logic [ADDR_W-1:0] addr;
        logic [FREE_W-1:0] free_left;
    } t_reply;

    class lease_pool;
        bit                busy [POOL_SLOTS];
        int unsigned       free_cnt;
        logic [ADDR_W-1:0] reg_net;
        logic [4:0]        reg_pfx;
        logic [ADDR_W-1:0] pool_net;
        int unsigned       pool_bits;
        t_reply            due_replies [$];
        int unsigned       fault_cnt;

        function new();
            reg_net   = '0;
            reg_pfx   = 5'd24;
            fault_cnt = 0;
            init_pool();
        endfunction

        function int unsigned host_mask();
            return (1 << pool_bits) - 1;
        endfunction

        function bit in_subnet(logic [ADDR_W-1:0] addr);
            return ((addr ^ pool_net) & ~ADDR_W'(host_mask())) == '0;
        endfunction

        function void reserve(int unsigned h);
            if (!busy[h]) begin
                busy[h] = 1'b1;
                free_cnt--;
            end
        endfunction

        function void init_pool();
            int unsigned hb;
            hb = 32 - reg_pfx;
            if (hb > MAX_HOST_BITS) hb = MAX_HOST_BITS;
            pool_bits = hb;
            pool_net  = reg_net & ~ADDR_W'(host_mask());
            foreach (busy[i]) busy[i] = 1'b0;
            free_cnt = 1 << pool_bits;
            // with a single host bit, broadcast minus one is the network address
            reserve(0);
            reserve(host_mask());
            reserve(host_mask() - 1);
        endfunction

        function void write_reg(t_reg_idx idx, logic [APB_DATA_W-1:0] data);
            if (idx == REG_NETWORK_ADDR) reg_net = data;
            else reg_pfx = data[4:0];
        endfunction

        // predict the reply of one accepted request beat
        function void take_request(logic [1:0] op, logic use_given, logic [ADDR_W-1:0] addr);
            t_reply      r;
            int unsigned mask;
            int unsigned h;
            bit          found;
            mask   = host_mask();
            r.status = ST_BAD_ADDR;
            r.addr   = '0;
            case (op)
                OP_INIT: begin
                    init_pool();
                    r.status = ST_OK;
                end
                OP_ALLOC: begin
                    if (!in_subnet(addr)) begin
                        r.status = ST_BAD_ADDR;
                    end else if (free_cnt == 0) begin
                        r.status = ST_NONE_FREE;
                    end else begin
                        // no wrap: search only upward from the start point
                        r.status = ST_NONE_FREE;
                        found = 1'b0;
                        for (h = use_given ? (addr & mask) : 0; h <= mask && !found; h++) begin
                            if (!busy[h]) begin
                                busy[h] = 1'b1;
                                free_cnt--;
                                r.addr   = pool_net | h;
                                r.status = ST_OK;
                                found    = 1'b1;
                            end
                        end
                    end
                end
                OP_FREE: begin
                    if (in_subnet(addr) && busy[addr & mask]) begin
                        busy[addr & mask] = 1'b0;
                        free_cnt++;
                        r.status = ST_OK;
                    end
                end
                default: r.status = ST_BAD_ADDR;
            endcase
            r.free_left = free_cnt[FREE_W-1:0];
            due_replies.push_back(r);
        endfunction

        function void match_reply(logic [1:0] status, logic [ADDR_W-1:0] addr,
                                  logic [FREE_W-1:0] free_left);
            t_reply r;
            if (due_replies.size() == 0) begin
                $display("%0t: unexpected reply beat: status %0d addr %h free %0d",
                         $time, status, addr, free_left);
                fault_cnt++;
            end else begin
                r = due_replies.pop_front();
                if (status !== r.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, r.status, status);
                    fault_cnt++;
                end
                if (addr !== r.addr) begin
                    $display("%0t: assigned_addr expected %h actual %h", $time, r.addr, addr);
                    fault_cnt++;
                end
                if (free_left !== r.free_left) begin
                    $display("%0t: free_left expected %0d actual %0d",
                             $time, r.free_left, free_left);
                    fault_cnt++;
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] apb_rdata;
    logic                  pready;

    saa_in_if                      req_if ();
    saa_out_if #(.FREE_W(FREE_W))  rsp_if ();

    subnet_address_allocator_top #(.MAX_HOST_BITS(MAX_HOST_BITS)) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (apb_rdata),
        .pready  (pready),
        .i_in    (req_if.sink),
        .o_out   (rsp_if.source)
    );

    lease_pool   sb = new();
    int unsigned src_idle;
    int unsigned snk_idle;
    int unsigned cycle_cnt;

    initial begin
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        req_if.valid     = 1'b0;
        req_if.op        = OP_INIT;
        req_if.use_given = 1'b0;
        req_if.address   = '0;
        rsp_if.ready     = 1'b0;
        src_idle         = 28;
        snk_idle         = 78;
        cycle_cnt        = 0;
    end

    always #1 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= snk_idle);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.match_reply(rsp_if.status, rsp_if.assigned_addr, rsp_if.free_left);
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_item(input logic [1:0] op, input logic use_given,
                             input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < src_idle) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.op        <= op;
        req_if.use_given <= use_given;
        req_if.address   <= addr;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.take_request(op, use_given, addr);
        @(negedge i_clk);
    endtask

    // ends the access with the bus idle so back-to-back writes keep a setup phase
    task automatic apb_write(input t_reg_idx idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_quiet();
        while (sb.due_replies.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    // registers only move while the allocator is idle; the init beat applies them
    task automatic reconfigure(input logic [ADDR_W-1:0] net, input logic [4:0] pfx);
        req_if.valid <= 1'b0;
        wait_quiet();
        apb_write(REG_NETWORK_ADDR, net);
        apb_write(REG_PREFIX_LEN, APB_DATA_W'(pfx));
        send_item(OP_INIT, 1'b0, $urandom());
    endtask

    task automatic play_random(input int n);
        logic [1:0]        op;
        logic              use_given;
        logic [ADDR_W-1:0] addr;
        int unsigned       mask;
        int unsigned       r;
        int unsigned       h;
        int unsigned       k;
        bit                found;
        repeat (n) begin
            mask      = sb.host_mask();
            r         = $urandom_range(99);
            use_given = 1'($urandom_range(1));
            addr      = sb.pool_net | $urandom_range(mask);
            if (r < 60) begin
                op        = OP_ALLOC;
                use_given = ($urandom_range(3) != 0);
                if ($urandom_range(9) == 0) addr = $urandom();
            end else if (r < 85) begin
                op = OP_FREE;
                if ($urandom_range(3) != 0) begin
                    // mostly release a host that is really in use
                    h     = $urandom_range(mask);
                    found = 1'b0;
                    for (k = 0; k <= mask && !found; k++) begin
                        if (sb.busy[(h + k) & mask]) begin
                            addr  = sb.pool_net | ((h + k) & mask);
                            found = 1'b1;
                        end
                    end
                end else if ($urandom_range(4) == 0) begin
                    addr = $urandom();
                end
            end else if (r < 89) begin
                op = OP_INIT;
            end else if (r < 94) begin
                op   = OP_UNUSED;
                addr = $urandom();
            end else begin
                op   = OP_ALLOC;
                addr = $urandom();
            end
            send_item(op, use_given, addr);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] net;
        logic [4:0]        pfx;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // default pool 0.0.0.0/24 from reset
        send_item(OP_ALLOC, 1'b0, 32'h0000_0000);
        send_item(OP_ALLOC, 1'b1, 32'h0000_00FD);
        send_item(OP_ALLOC, 1'b1, 32'h0000_00FE);   // only reserved above
        send_item(OP_ALLOC, 1'b1, 32'h0000_00FF);
        send_item(OP_ALLOC, 1'b1, 32'h0000_0100);   // outside subnet
        send_item(OP_ALLOC, 1'b0, 32'hFFFF_FFFF);
        send_item(OP_FREE,  1'b0, 32'h0000_0000);   // reserved network address
        send_item(OP_FREE,  1'b0, 32'h0000_0000);   // no longer in use
        send_item(OP_FREE,  1'b1, 32'hFFFF_FFFF);
        send_item(OP_FREE,  1'b0, 32'h0000_00FF);
        send_item(OP_ALLOC, 1'b1, 32'h0000_00FE);
        send_item(OP_ALLOC, 1'b1, 32'h0000_0000);
        send_item(OP_UNUSED, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_FREE,  1'b0, 32'h0000_0001);
        send_item(OP_INIT,  1'b1, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 1'b1, 32'h0000_00AA);
        send_item(OP_ALLOC, 1'b1, 32'h0000_0055);

        // one host bit: all reserved, pool starts empty
        reconfigure(32'hFFFF_FFFF, 5'd31);
        send_item(OP_ALLOC, 1'b0, 32'hFFFF_FFFF);
        send_item(OP_FREE,  1'b0, 32'hFFFF_FFFF);
        send_item(OP_FREE,  1'b0, 32'hFFFF_FFFE);
        send_item(OP_ALLOC, 1'b0, 32'hFFFF_FFFE);
        send_item(OP_ALLOC, 1'b1, 32'hFFFF_FFFF);
        send_item(OP_ALLOC, 1'b1, 32'hFFFF_FFFE);

        for (int seg = 0; seg < 9; seg++) begin
            case (seg / 3)
                0: begin
                    src_idle = 28;
                    snk_idle = 78;
                end
                1: begin
                    src_idle = 78;
                    snk_idle = 28;
                end
                default: begin
                    src_idle = 0;
                    snk_idle = 0;
                end
            endcase
            pfx = SEG_PFX[seg];
            if (seg == 4) pfx = 5'($urandom_range(23));
            net = (seg == 0) ? '1 : (seg == 3) ? '0 : $urandom();
            reconfigure(net, pfx);
            play_random(SEG_ITEMS);
        end

        req_if.valid <= 1'b0;
        wait_quiet();
        if (sb.fault_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
